@@ hw/rtl/dhcp_option_scanner_top_defines.svh @@
// Assertion macros of the DHCP option scanner RTL.
`ifndef DHCP_OPTION_SCANNER_TOP_DEFINES_SVH
`define DHCP_OPTION_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked at every clock edge outside reset.
`define DOS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("dhcp option scanner: assertion failed");
// Checked at every clock edge, including those in reset.
`define DOS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("dhcp option scanner: assertion failed");
`else
`define DOS_ASSERT(label, prop)
`define DOS_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ hw/rtl/dos_pkg.sv @@
// Types and constants of the DHCP option scanner.
package dos_pkg;

   // Field widths.
   localparam int OPT_W      = 8;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 8;
   localparam int TAKEN_W    = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_FIRST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_LAST  = 1'b1;

   // Option codes of interest.
   localparam logic [OPT_W-1:0] CODE_PAD  = 8'd0;
   localparam logic [OPT_W-1:0] CODE_END  = 8'd255;
   localparam logic [OPT_W-1:0] CODE_TYPE = 8'd53;
   localparam logic [OPT_W-1:0] CODE_ADDR = 8'd50;

   // Length of a well-formed requested-address record.
   localparam logic [LEN_W-1:0]   ADDR_LEN   = 8'd4;
   localparam logic [TAKEN_W-1:0] ADDR_BYTES = 3'd4;

   // Scan phase, one-hot.
   typedef enum logic [3:0] {
      PH_CODE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_STOP = 4'b1000
   } phase_type;

   // Which record the current data bytes belong to.
   typedef enum logic [1:0] {
      TG_NONE      = 2'd0,
      TG_TYPE      = 2'd1,
      TG_ADDR      = 2'd2,
      TG_TYPE_REST = 2'd3
   } target_type;

endpackage

@@ hw/rtl/dos_if.sv @@
// Request and result channel interfaces of the DHCP option scanner.
interface dos_req_if;
   import dos_pkg::*;
   logic             valid;
   logic             ready;
   logic [OPT_W-1:0] opt_byte;
   logic             last_byte;
   modport source (output valid, opt_byte, last_byte, input ready);
   modport sink   (input valid, opt_byte, last_byte, output ready);
endinterface

interface dos_rsp_if;
   import dos_pkg::*;
   logic              valid;
   logic              ready;
   logic [OPT_W-1:0]  msg_kind;
   logic              req_addr_valid;
   logic [ADDR_W-1:0] req_addr;
   logic              req_addr_in_pool;
   logic              truncated;
   modport source (output valid, msg_kind, req_addr_valid, req_addr, req_addr_in_pool,
                   truncated, input ready);
   modport sink   (input valid, msg_kind, req_addr_valid, req_addr, req_addr_in_pool,
                   truncated, output ready);
endinterface

@@ hw/rtl/dhcp_option_scanner_top.sv @@
// DHCP options-area scanner: walks option records and reports type and requested address.
//
// Usage: the options area of one message enters on req_chan, one byte per request,
// with last_byte set on its final byte. Only that final request produces a result on
// rsp_chan: the message type, the requested address with its valid and in-pool flags,
// and whether a wanted record was cut short. Bytes beyond OPTIONS_BYTES are ignored.
// The pool bounds are to be written through the csr_ port while no message is in
// flight; the block itself does not enforce this. Throughput: one request per cycle
// while req_chan.ready is high; the scan state is updated by the byte as it is taken,
// so there is no per-message gap. A final byte loads the capture register as it is
// taken; the pool compare then feeds the result register, which drives rsp_chan.
// Reset clears the scan state, the pool bounds and the valid flags of both result stages.
// When the receiver stalls, the result register holds and the capture stage fills;
// requests keep being taken until a second result is waiting behind the first, and
// req_chan.ready then drops until the result register drains.
module dhcp_option_scanner_top #(
   parameter int OPTIONS_BYTES = 308
) (
   input  logic                           clock,
   input  logic                           reset,
   dos_req_if.sink                        req_chan,
   dos_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [dos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dos_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dos_pkg::*;
`include "dhcp_option_scanner_top_defines.svh"

   localparam int POS_W = $clog2(OPTIONS_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(OPTIONS_BYTES);

   // Configuration registers.
   logic [ADDR_W-1:0] pool_first_ff;
   logic [ADDR_W-1:0] pool_last_ff;

   // Per-message scan state.
   phase_type           phase_ff, phase_in;
   target_type          target_ff, target_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;
   logic                type_seen_ff, type_seen_in;
   logic [OPT_W-1:0]    type_value_ff, type_value_in;
   logic                addr_seen_ff, addr_seen_in;
   logic                addr_len_ok_ff, addr_len_ok_in;
   logic [TAKEN_W-1:0]  taken_ff, taken_in;
   logic [ADDR_W-1:0]   addr_shift_ff, addr_shift_in;

   // Capture stage: scan outcome of a finished message.
   logic                s1_valid_ff;
   logic [OPT_W-1:0]    s1_type_ff, s1_type_in;
   logic                s1_addr_valid_ff, s1_addr_valid_in;
   logic [ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic                s1_trunc_ff, s1_trunc_in;

   // Result register.
   logic                out_valid_ff;
   logic [OPT_W-1:0]    out_type_ff;
   logic                out_addr_valid_ff;
   logic [ADDR_W-1:0]   out_addr_ff;
   logic                out_in_pool_ff;
   logic                out_trunc_ff;

   logic out_move;
   logic s1_move;
   logic take;
   logic [OPT_W-1:0] b;

   // Handshake: the result register moves when empty or taken, the capture stage
   // moves into it, and requests are taken while the capture stage has room.
   assign out_move = !out_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_move;
   assign req_chan.ready = !s1_valid_ff || out_move;
   assign take = req_chan.valid && req_chan.ready;
   assign b = req_chan.opt_byte;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_first_ff <= '0;
         pool_last_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POOL_FIRST: pool_first_ff <= csr_wdata;
            CSR_POOL_LAST:  pool_last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One step of the record walk, then the outcome and the clear on the final byte.
   always_comb begin
      phase_in      = phase_ff;
      target_in     = target_ff;
      pos_in        = pos_ff;
      remaining_in  = remaining_ff;
      type_seen_in  = type_seen_ff;
      type_value_in = type_value_ff;
      addr_seen_in  = addr_seen_ff;
      addr_len_ok_in = addr_len_ok_ff;
      taken_in      = taken_ff;
      addr_shift_in = addr_shift_ff;

      if (pos_ff < POS_LIMIT) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            PH_CODE: begin
               if (b == CODE_END) begin
                  phase_in = PH_STOP;
               end else if (b != CODE_PAD) begin
                  target_in = TG_NONE;
                  if (b == CODE_TYPE && !type_seen_ff) begin
                     type_seen_in = 1'b1;
                     target_in    = TG_TYPE;
                  end else if (b == CODE_ADDR && !addr_seen_ff) begin
                     addr_seen_in = 1'b1;
                     target_in    = TG_ADDR;
                  end
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               remaining_in = b;
               if (target_ff == TG_ADDR) begin
                  addr_len_ok_in = (b == ADDR_LEN);
               end
               if (b == '0) begin
                  phase_in  = PH_CODE;
                  target_in = TG_NONE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if (target_ff == TG_TYPE) begin
                  type_value_in = b;
                  target_in     = TG_TYPE_REST;
               end else if (target_ff == TG_ADDR && addr_len_ok_ff && taken_ff < ADDR_BYTES) begin
                  addr_shift_in = {addr_shift_ff[ADDR_W-OPT_W-1:0], b};
                  taken_in      = taken_ff + 1'b1;
               end
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == LEN_W'(1)) begin
                  phase_in  = PH_CODE;
                  target_in = TG_NONE;
               end
            end
            PH_STOP: ;
            default: ;
         endcase
      end

      // Outcome of the message as it stands after this byte.
      s1_type_in       = type_value_in;
      s1_addr_valid_in = addr_seen_in && addr_len_ok_in && (taken_in == ADDR_BYTES);
      s1_addr_in       = s1_addr_valid_in ? addr_shift_in : '0;
      s1_trunc_in      = (target_in != TG_NONE) &&
                         (phase_in == PH_LEN || phase_in == PH_DATA);

      // The final byte returns the scan to its starting state.
      if (req_chan.last_byte) begin
         phase_in       = PH_CODE;
         target_in      = TG_NONE;
         pos_in         = '0;
         remaining_in   = '0;
         type_seen_in   = 1'b0;
         type_value_in  = '0;
         addr_seen_in   = 1'b0;
         addr_len_ok_in = 1'b0;
         taken_in       = '0;
         addr_shift_in  = '0;
      end
   end

   // Scan state registers, updated on each request taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CODE;
         target_ff      <= TG_NONE;
         pos_ff         <= '0;
         remaining_ff   <= '0;
         type_seen_ff   <= 1'b0;
         type_value_ff  <= '0;
         addr_seen_ff   <= 1'b0;
         addr_len_ok_ff <= 1'b0;
         taken_ff       <= '0;
         addr_shift_ff  <= '0;
      end else if (take) begin
         phase_ff       <= phase_in;
         target_ff      <= target_in;
         pos_ff         <= pos_in;
         remaining_ff   <= remaining_in;
         type_seen_ff   <= type_seen_in;
         type_value_ff  <= type_value_in;
         addr_seen_ff   <= addr_seen_in;
         addr_len_ok_ff <= addr_len_ok_in;
         taken_ff       <= taken_in;
         addr_shift_ff  <= addr_shift_in;
      end
   end

   // Capture stage: loaded by a final byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take && req_chan.last_byte) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_chan.last_byte) begin
         s1_type_ff       <= s1_type_in;
         s1_addr_valid_ff <= s1_addr_valid_in;
         s1_addr_ff       <= s1_addr_in;
         s1_trunc_ff      <= s1_trunc_in;
      end
   end

   // Result register: the pool bounds check is done on the way in.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_move) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_type_ff       <= s1_type_ff;
         out_addr_valid_ff <= s1_addr_valid_ff;
         out_addr_ff       <= s1_addr_ff;
         out_in_pool_ff    <= s1_addr_valid_ff && (s1_addr_ff >= pool_first_ff) &&
                              (s1_addr_ff <= pool_last_ff);
         out_trunc_ff      <= s1_trunc_ff;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.msg_kind         = out_type_ff;
   assign rsp_chan.req_addr_valid   = out_addr_valid_ff;
   assign rsp_chan.req_addr         = out_addr_ff;
   assign rsp_chan.req_addr_in_pool = out_in_pool_ff;
   assign rsp_chan.truncated        = out_trunc_ff;

   // A result in the pool always carries a valid address.
   `DOS_ASSERT(a_pool_needs_valid, out_valid_ff && out_in_pool_ff |-> out_addr_valid_ff)
   // An invalid address is reported as zero.
   `DOS_ASSERT(a_invalid_addr_zero, out_valid_ff && !out_addr_valid_ff |-> out_addr_ff == '0)
   // A waiting capture stage behind a stalled result blocks requests.
   `DOS_ASSERT(a_full_blocks, s1_valid_ff && !out_move |-> !req_chan.ready)
   // A final byte leaves the scan at its starting state.
   `DOS_ASSERT(a_final_clears, take && req_chan.last_byte |=> phase_ff == PH_CODE && pos_ff == '0)
   // Never more than four address bytes are gathered.
   `DOS_ASSERT(a_taken_bound, taken_ff <= ADDR_BYTES)
   // Nothing is offered right after reset.
   `DOS_ASSERT_ALWAYS(a_reset_empty, reset |=> !out_valid_ff && !s1_valid_ff)

endmodule
